[rtl/vifbc_pkg.sv]
// Package for the VLAN/IPv4 flow byte counter.
// Holds the result codes, protocol constants and the structs passed between modules.
// No dependencies.
package vifbc_pkg;

  localparam int unsigned TableEntriesDef = 1024;
  localparam int unsigned MaxVlanTagsDef  = 2;

  localparam logic [15:0] PROTO_VLAN_Q  = 16'h8100;
  localparam logic [15:0] PROTO_VLAN_AD = 16'h88a8;
  localparam logic [15:0] PROTO_IPV4    = 16'h0800;
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam int unsigned EthHdrLen     = 14;
  localparam int unsigned VlanTagLen    = 4;
  localparam int unsigned IpHdrLen      = 20;
  localparam logic [5:0]  POS_MAX       = 6'd63;

  typedef enum logic [2:0] {
    STAT_EXIST  = 3'd0,
    STAT_NEW    = 3'd1,
    STAT_NOT_IP = 3'd2,
    STAT_TRUNC  = 3'd3,
    STAT_FULL   = 3'd4,
    STAT_READ   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_SEARCH,
    ENG_UPDATE,
    ENG_RDWAIT,
    ENG_DONE
  } eng_state_e;

  // Summary of a frame at its last byte
  typedef struct packed {
    logic        ok;
    status_e     stat;
    logic [15:0] len;
    logic [31:0] src;
    logic [31:0] dst;
  } frm_t;

  // One result item
  typedef struct packed {
    status_e     stat;
    logic        slot_valid;
    logic [31:0] src;
    logic [31:0] dst;
    logic [63:0] bytes;
    logic [15:0] ip_len;
  } res_t;

endpackage

[rtl/vifbc_parser.sv]
// Byte-serial Ethernet/VLAN/IPv4 header parser.
// Captures total length and addresses; depends on vifbc_pkg.
module vifbc_parser import vifbc_pkg::*; #(
  parameter int unsigned MAX_VLAN_TAGS = MaxVlanTagsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_acc_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output frm_t       frm_o
);

  localparam logic [6:0] VlanLimit = 7'(EthHdrLen + VlanTagLen * MAX_VLAN_TAGS);

  logic [5:0]  pos_q, pos_d;
  logic [4:0]  start_q, start_d;
  logic [15:0] proto_q, proto_d;
  logic        ver_q, ver_d;
  logic [15:0] len_q, len_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;

  logic [6:0]  p7, s7, len7, sd7;
  logic [4:0]  off;
  logic [15:0] pr;

  // Per-byte field extraction
  always_comb begin
    pos_d   = pos_q;
    start_d = start_q;
    proto_d = proto_q;
    ver_d   = ver_q;
    len_d   = len_q;
    src_d   = src_q;
    dst_d   = dst_q;
    p7      = {1'b0, pos_q};
    s7      = {2'b0, start_q};
    off     = 5'(p7 - s7);
    pr      = {proto_q[15:8], data_byte_i};
    if (p7 == s7 - 7'd2) begin
      proto_d = {data_byte_i, 8'h00};
    end else if (p7 == s7 - 7'd1) begin
      proto_d = pr;
      if ((pr == PROTO_VLAN_Q || pr == PROTO_VLAN_AD) && s7 < VlanLimit) begin
        start_d = start_q + 5'(VlanTagLen);
      end
    end else if (p7 >= s7 && p7 < s7 + 7'(IpHdrLen)) begin
      if (off == 5'd0) begin
        ver_d = (data_byte_i[7:4] == IP_VERSION);
      end else if (off == 5'd2 || off == 5'd3) begin
        len_d = {len_q[7:0], data_byte_i};
      end else if (off >= 5'd12 && off <= 5'd15) begin
        src_d = {src_q[23:0], data_byte_i};
      end else if (off >= 5'd16) begin
        dst_d = {dst_q[23:0], data_byte_i};
      end
    end
    if (pos_q != POS_MAX) begin
      pos_d = pos_q + 6'd1;
    end
  end

  // Frame verdict from the updated fields
  always_comb begin
    len7       = {1'b0, pos_d};
    sd7        = {2'b0, start_d};
    frm_o.ok   = 1'b0;
    frm_o.stat = STAT_TRUNC;
    frm_o.len  = len_d;
    frm_o.src  = src_d;
    frm_o.dst  = dst_d;
    if (len7 < sd7) begin
      frm_o.stat = STAT_TRUNC;
    end else if (proto_d != PROTO_IPV4) begin
      frm_o.stat = STAT_NOT_IP;
    end else if (len7 < sd7 + 7'(IpHdrLen)) begin
      frm_o.stat = STAT_TRUNC;
    end else if (!ver_d) begin
      frm_o.stat = STAT_NOT_IP;
    end else begin
      frm_o.ok   = 1'b1;
      frm_o.stat = STAT_NEW;
    end
  end

  // Parse registers; cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= 5'(EthHdrLen);
      proto_q <= '0;
      ver_q   <= 1'b0;
      len_q   <= '0;
      src_q   <= '0;
      dst_q   <= '0;
    end else if (byte_acc_i) begin
      if (last_byte_i) begin
        pos_q   <= '0;
        start_q <= 5'(EthHdrLen);
        proto_q <= '0;
        ver_q   <= 1'b0;
        len_q   <= '0;
        src_q   <= '0;
        dst_q   <= '0;
      end else begin
        pos_q   <= pos_d;
        start_q <= start_d;
        proto_q <= proto_d;
        ver_q   <= ver_d;
        len_q   <= len_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
      end
    end
  end

endmodule

[rtl/vifbc_table.sv]
// Flow table: key and count memories with a linear search engine and output register.
// Depends on vifbc_pkg.
module vifbc_table import vifbc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic        req_type_i,
  input  logic        last_byte_i,
  input  logic [9:0]  slot_index_i,
  input  frm_t        frm_i,
  output logic        busy_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output res_t        res_o
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned UW = AW + 1;
  localparam int unsigned CW = (UW > 10) ? UW : 10;
  localparam logic [UW-1:0] Entries = UW'(TABLE_ENTRIES);

  eng_state_e state_q, state_d;

  logic [63:0]   key_mem [TABLE_ENTRIES];
  logic [63:0]   cnt_mem [TABLE_ENTRIES];
  logic [63:0]   key_rd_q, cnt_rd_q;

  logic [UW-1:0] used_q, used_d;
  logic [UW-1:0] scan_q, scan_d;
  logic [AW-1:0] chk_addr_q, chk_addr_d;
  logic          chk_vld_q, chk_vld_d;
  logic [63:0]   key_q, key_d;
  logic [15:0]   len_q, len_d;
  res_t          res_q, res_d;
  res_t          out_q;
  logic          out_valid_q;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          key_we, cnt_we;
  logic [AW-1:0] wr_addr;
  logic [63:0]   cnt_wdata;
  logic [CW-1:0] idx_ext, used_ext;
  logic          hit;
  logic          out_load;

  assign idx_ext  = CW'(slot_index_i);
  assign used_ext = CW'(used_q);
  assign hit      = chk_vld_q && (key_rd_q == key_q);
  assign out_load = (state_q == ENG_DONE) && (!out_valid_q || !out_stall_i);
  assign busy_o   = (state_q != ENG_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ENG_IDLE: begin
        if (acc_i && req_type_i) begin
          state_d = (idx_ext < used_ext) ? ENG_RDWAIT : ENG_DONE;
        end else if (acc_i && last_byte_i) begin
          state_d = frm_i.ok ? ENG_SEARCH : ENG_DONE;
        end
      end
      ENG_SEARCH: begin
        if (hit) begin
          state_d = ENG_UPDATE;
        end else if (scan_q >= used_q && !chk_vld_q) begin
          state_d = ENG_DONE;
        end
      end
      ENG_UPDATE: state_d = ENG_DONE;
      ENG_RDWAIT: state_d = ENG_DONE;
      ENG_DONE: begin
        if (out_load) begin
          state_d = ENG_IDLE;
        end
      end
      default: state_d = ENG_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    used_d     = used_q;
    scan_d     = scan_q;
    chk_addr_d = chk_addr_q;
    chk_vld_d  = 1'b0;
    key_d      = key_q;
    len_d      = len_q;
    res_d      = res_q;
    rd_en      = 1'b0;
    rd_addr    = scan_q[AW-1:0];
    key_we     = 1'b0;
    cnt_we     = 1'b0;
    wr_addr    = used_q[AW-1:0];
    cnt_wdata  = 64'(len_q);
    case (state_q)
      ENG_IDLE: begin
        if (acc_i && req_type_i) begin
          res_d      = '0;
          res_d.stat = STAT_READ;
          rd_addr    = idx_ext[AW-1:0];
          rd_en      = (idx_ext < used_ext);
        end else if (acc_i && last_byte_i) begin
          res_d      = '0;
          res_d.stat = frm_i.stat;
          key_d      = {frm_i.src, frm_i.dst};
          len_d      = frm_i.len;
          scan_d     = '0;
        end
      end
      ENG_SEARCH: begin
        res_d.src    = key_q[63:32];
        res_d.dst    = key_q[31:0];
        res_d.ip_len = len_q;
        if (hit) begin
          chk_addr_d = chk_addr_q;
        end else if (scan_q < used_q) begin
          rd_en      = 1'b1;
          chk_vld_d  = 1'b1;
          chk_addr_d = scan_q[AW-1:0];
          scan_d     = scan_q + UW'(1);
        end else if (!chk_vld_q) begin
          if (used_q < Entries) begin
            key_we      = 1'b1;
            cnt_we      = 1'b1;
            used_d      = used_q + UW'(1);
            res_d.stat  = STAT_NEW;
            res_d.bytes = 64'(len_q);
          end else begin
            res_d.stat  = STAT_FULL;
            res_d.bytes = '0;
          end
        end
      end
      ENG_UPDATE: begin
        cnt_wdata   = cnt_rd_q + 64'(len_q);
        cnt_we      = 1'b1;
        wr_addr     = chk_addr_q;
        res_d.stat  = STAT_EXIST;
        res_d.bytes = cnt_wdata;
      end
      ENG_RDWAIT: begin
        res_d.slot_valid = 1'b1;
        res_d.src        = key_rd_q[63:32];
        res_d.dst        = key_rd_q[31:0];
        res_d.bytes      = cnt_rd_q;
      end
      default: ;
    endcase
  end

  // Table memories with a registered read
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_q;
    end
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr];
      cnt_rd_q <= cnt_mem[rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    len_q      <= len_d;
    res_q      <= res_d;
    chk_addr_q <= chk_addr_d;
    scan_q     <= scan_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ENG_IDLE;
      used_q      <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      chk_vld_q <= chk_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

[rtl/vlan_ipv4_flow_byte_counter.sv]
// Top level of the VLAN/IPv4 flow byte counter.
// Instantiates vifbc_parser and vifbc_table; depends on vifbc_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries either a frame byte
//   (req_type_i = 0, data_byte_i, last_byte_i) or a slot read (req_type_i = 1,
//   slot_index_i). Output channel (out_valid_o / out_stall_i) returns one
//   result per last frame byte and per read.
//   Frame bytes that are not last are taken whenever the engine is idle,
//   even while a result waits at the output.
//   A last byte starts a linear search of the flow table: one memory read
//   per cycle over the used slots. A miss scans every used slot; a hit ends
//   the scan early and is followed by the count read-modify-write.
//   A read of an unused slot skips the memory read.
//   in_stall_o is high while the search/read engine is busy.
//   When the receiver stalls, the result holds in the output register and
//   the engine waits in its done state; further frame bytes are stalled
//   only once the engine is busy.
//   Reset clears the parser, the slot count and the output valid; the
//   table memories are not cleared, slots beyond the count are never read.
module vlan_ipv4_flow_byte_counter import vifbc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned MAX_VLAN_TAGS = MaxVlanTagsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [9:0]  slot_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        slot_valid_o,
  output logic [31:0] flow_src_o,
  output logic [31:0] flow_dst_o,
  output logic [63:0] flow_bytes_o,
  output logic [15:0] frame_ip_len_o
);

  logic acc;
  logic busy;
  frm_t frm;
  res_t res;

  // Input transfer
  assign acc        = in_valid_i && !busy;
  assign in_stall_o = busy;

  vifbc_parser #(
    .MAX_VLAN_TAGS(MAX_VLAN_TAGS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_acc_i (acc && !req_type_i),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .frm_o      (frm)
  );

  vifbc_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .req_type_i  (req_type_i),
    .last_byte_i (last_byte_i),
    .slot_index_i(slot_index_i),
    .frm_i       (frm),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // Result fields
  assign status_o       = res.stat;
  assign slot_valid_o   = res.slot_valid;
  assign flow_src_o     = res.src;
  assign flow_dst_o     = res.dst;
  assign flow_bytes_o   = res.bytes;
  assign frame_ip_len_o = res.ip_len;

endmodule
